@@ sv/dfh_pkg.sv @@
`timescale 1ns / 1ps

package dfh_pkg;

  // Width of the message byte counter; the count saturates at all ones.
  localparam int LENGTH_BITS = 32;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] DOMAIN_TAG_RESET = 64'h4558_504C_4943_4954;

  // A 64-bit word folds in as eight bytes, least significant first.
  localparam logic [2:0] LAST_FOLD_STEP = 3'd7;

endpackage

@@ sv/dfh_fold_unit.sv @@
`timescale 1ns / 1ps

// One FNV-1a round: xor the byte in, then multiply by the 64-bit FNV prime.
// The prime is 2^40 + 2^8 + 0xB3, so the product is a sum of shifted copies.
module dfh_fold_unit
  import dfh_pkg::*;
(
  input  logic [63:0] hash_in,
  input  logic [7:0]  byte_in,
  output logic [63:0] hash_out
);

  logic [63:0] mixed;

  assign mixed = hash_in ^ {56'd0, byte_in};

  assign hash_out = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                  + (mixed << 4) + (mixed << 1) + mixed;

endmodule

@@ sv/domain_framed_fnv1a64_hash_unit.sv @@
`timescale 1ns / 1ps

// Domain-framed 64-bit FNV-1a hasher. Each input item carries a message byte
// (tdata), a flag that the byte is present (tuser) and an end-of-message mark
// (tlast). The first item of a message that has a byte or tlast opens it: the
// hash starts at the FNV offset basis and the 64-bit domain tag, sampled at
// that item, is folded in low byte first. Each present byte is folded in and
// counted; the count saturates at all ones and then sets the overflow flag.
// On tlast the count is folded in as eight little-endian bytes and one result
// item leaves on the master side: the hash in tdata, the overflow flag in
// tuser. An item with neither a byte nor tlast is dropped. A single shared
// fold unit does one xor-and-multiply round per cycle under a small
// sequencer, and the slave side is ready only while the sequencer is idle.
// Steps per accepted item: the sequencer takes it in the idle state; the item
// that opens a message then folds the tag, an item that carries a byte folds
// it, and an item with tlast folds the length and then loads the output
// register, waiting there only while a previous result is still not taken.
// The output register lets the next message start while a result waits.
module domain_framed_fnv1a64_hash_unit
  import dfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration: domain tag
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_valid
  input  logic        s_tlast,   // end of message
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] hash_out
  output logic        m_tuser    // [0] length_overflow
);

  localparam logic [2:0] ST_IDLE = 3'd0;  // ready for the next item
  localparam logic [2:0] ST_TAG  = 3'd1;  // fold the domain tag
  localparam logic [2:0] ST_DATA = 3'd2;  // fold the message byte
  localparam logic [2:0] ST_LEN  = 3'd3;  // fold the byte count
  localparam logic [2:0] ST_EMIT = 3'd4;  // hand the hash to the output register

  logic [2:0]             state;
  logic [63:0]            domain_tag;
  logic [63:0]            hash;
  logic [63:0]            word;      // tag or count, shifted out a byte per step
  logic [2:0]             step;
  logic [LENGTH_BITS-1:0] count;
  logic                   sat;
  logic                   in_msg;
  logic [7:0]             byte_q;
  logic                   vld_q;
  logic                   last_q;

  logic [7:0]             fold_byte;
  logic [63:0]            fold_hash;
  logic                   sat_hit;
  logic [LENGTH_BITS-1:0] count_next;

  assign s_tready = (state == ST_IDLE);

  // The data step folds the held byte; tag and length steps fold the low byte.
  assign fold_byte = (state == ST_DATA) ? byte_q : word[7:0];

  dfh_fold_unit u_fold (
    .hash_in  (hash),
    .byte_in  (fold_byte),
    .hash_out (fold_hash)
  );

  // Hold the count at all ones once it gets there.
  assign sat_hit    = (count == COUNT_MAX);
  assign count_next = sat_hit ? count : count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_msg     <= 1'b0;
      m_tvalid   <= 1'b0;
      step       <= '0;
      domain_tag <= DOMAIN_TAG_RESET;
    end else begin
      if (cfg_we) begin
        domain_tag <= cfg_data;
      end
      // Drop the taken result unless the emit step refills the register.
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            byte_q <= s_tdata;
            vld_q  <= s_tuser;
            last_q <= s_tlast;
            if (s_tuser || s_tlast) begin
              step <= '0;
              if (!in_msg) begin
                // Open a message: start from the offset basis, sample the tag.
                hash   <= FNV_OFFSET_BASIS;
                word   <= domain_tag;
                count  <= '0;
                sat    <= 1'b0;
                in_msg <= 1'b1;
                state  <= ST_TAG;
              end else if (s_tuser) begin
                state <= ST_DATA;
              end else begin
                word  <= 64'(count);
                state <= ST_LEN;
              end
            end
          end
        end

        ST_TAG: begin
          hash <= fold_hash;
          step <= 3'(step + 1'b1);
          if (step == LAST_FOLD_STEP) begin
            if (vld_q) begin
              state <= ST_DATA;
            end else begin
              word  <= 64'(count);
              state <= ST_LEN;
            end
          end else begin
            word <= word >> 8;
          end
        end

        ST_DATA: begin
          hash  <= fold_hash;
          count <= count_next;
          if (sat_hit) begin
            sat <= 1'b1;
          end
          if (last_q) begin
            word  <= 64'(count_next);
            step  <= '0;
            state <= ST_LEN;
          end else begin
            state <= ST_IDLE;
          end
        end

        ST_LEN: begin
          hash <= fold_hash;
          word <= word >> 8;
          step <= 3'(step + 1'b1);
          if (step == LAST_FOLD_STEP) begin
            state <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          // Load the output register once it is free or being emptied.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= hash;
            m_tuser  <= sat;
            in_msg   <= 1'b0;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/dfh_checker.sv @@
`timescale 1ns / 1ps

module dfh_checker
  import dfh_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  logic s_acc;

  assign s_acc = s_tvalid && s_tready;

  // An item with a byte or an end mark keeps the hasher busy next cycle.
  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    s_acc && (s_tuser || s_tlast) |=> !s_tready)
    else $error("slave side ready right after a working item");

  // An item with neither byte nor end mark is dropped at once.
  a_idle_item_dropped: assert property (@(posedge clk) disable iff (rst)
    s_acc && !s_tuser && !s_tlast |=> s_tready)
    else $error("slave side not ready after an idle item");

  // The length fold keeps the slave side closed after an end mark.
  a_length_fold_busy: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tlast |=> ##8 !s_tready)
    else $error("slave side ready before the length fold finished");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

endmodule

bind domain_framed_fnv1a64_hash_unit dfh_checker u_dfh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
